### rtl/core/spq_pkg.sv
package spq_pkg;

    // Queue depth and derived widths
    localparam int DEPTH   = 128;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 8;

    // Request codes
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic                      shift_in;   // insert the value
        logic                      shift_out;  // remove the head
        logic signed [VALUE_W-1:0] value;      // value being inserted
    } cell_ctrl_t;

endpackage

### rtl/core/sorted_priority_queue.sv
// Sorted min-priority queue of signed 32-bit values, held in a chain of
// compare-and-shift cells with the smallest value always in the first cell.
// Input channel s_*: s_tuser carries the request kind (insert, remove
// smallest, peek smallest, no-op), s_tdata the value to insert.
// Output channel m_*: one item per request; m_tuser carries the status
// (ok, empty, full), m_tdata the returned value and the occupancy after
// the request.
// The result is registered and appears in the cycle after acceptance.
// Throughput: one request per cycle unless stalled; every cell compares
// and shifts in the same cycle, so inserts and removes run back to back.
// Equal values leave in arrival order. An insert into a full queue and a
// remove or peek on an empty queue leave the queue unchanged.
// Reset empties the queue (the entry count is cleared; cell contents are
// not) and drops any pending result.
// When the receiver stalls, the result is held in the output register and
// one further request is taken only as the held result is taken.
module sorted_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic [39:0] m_tdata    // [31:0] result_value, [39:32] occupancy
);
    import spq_pkg::*;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VALUE_W-1:0] result_reg;
    logic signed [VALUE_W-1:0] result_next;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;

    logic                      accept;
    kind_t                     kind;
    logic                      full;
    logic                      empty;
    cell_ctrl_t                ctrl;

    logic                      occ   [DEPTH];
    logic                      gt    [DEPTH];
    logic signed [VALUE_W-1:0] entry [DEPTH];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    // Broadcast the request to the chain
    assign ctrl.shift_in  = accept && (kind == KIND_INSERT) && !full;
    assign ctrl.shift_out = accept && (kind == KIND_REMOVE) && !empty;
    assign ctrl.value     = $signed(s_tdata);

    // Build the chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occ[i] = (count_reg > CNT_W'(i));

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occ         (occ[i]),
            .gt_left     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
            .entry_left  (entry[(i == 0) ? 0 : i - 1]),
            .entry_right (entry[(i == DEPTH - 1) ? i : i + 1]),
            .gt          (gt[i]),
            .entry       (entry[i])
        );
    end

    // Work out the result and the new count
    always_comb
    begin
        count_next   = count_reg;
        status_next  = status_reg;
        result_next  = result_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (accept)
        begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            result_next  = '0;
            unique case (kind)
                KIND_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + 1'b1;
                end
                KIND_REMOVE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        result_next = entry[0];
                        count_next  = count_reg - 1'b1;
                    end
                end
                KIND_PEEK:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        result_next = entry[0];
                end
                KIND_NOP:
                begin
                    status_next = ST_OK;
                end
            endcase
            occ_next = OCC_W'(count_next);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
        occ_reg    <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {occ_reg, result_reg};

endmodule

### rtl/core/spq_cell.sv
module spq_cell (
    input  logic                               clk,
    input  spq_pkg::cell_ctrl_t                ctrl,
    input  logic                               occ,         // this cell holds an entry
    input  logic                               gt_left,     // left cell would move right
    input  logic signed [spq_pkg::VALUE_W-1:0] entry_left,
    input  logic signed [spq_pkg::VALUE_W-1:0] entry_right,
    output logic                               gt,          // entry is after the new value
    output logic signed [spq_pkg::VALUE_W-1:0] entry
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    // An empty cell counts as larger than any value; equal values stay ahead
    assign gt = !occ || (entry_reg > ctrl.value);

    // Pick the next entry: open a slot on insert, pull from the right on remove
    always_comb
    begin
        priority if (ctrl.shift_in && gt)
        begin
            entry_next = gt_left ? entry_left : ctrl.value;
        end
        else if (ctrl.shift_out)
        begin
            entry_next = entry_right;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### tb/sorted_priority_queue_checker.sv
`timescale 1ns / 1ps

module sorted_priority_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [1:0]  m_tuser,
    input  logic [39:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    import spq_pkg::*;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] value;
        logic [OCC_W-1:0]          occupancy;
    } result_t;

    // Shadow of the sorted store, smallest value in entry 0
    logic signed [VALUE_W-1:0] store [DEPTH];
    int                        held;
    result_t                   awaited_q [$];
    int                        result_index;

    initial begin
        fail_count   = 0;
        pending      = 0;
        held         = 0;
        result_index = 0;
    end

    // Apply one request to the shadow store and return the result it gives
    function automatic result_t apply_request(kind_t kind, logic signed [VALUE_W-1:0] value);
        result_t r;
        int      i;
        r.status = ST_OK;
        r.value  = '0;
        case (kind)
            KIND_INSERT:
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // Equal entries stay ahead of the new value
                    i = held;
                    while (i > 0 && store[i-1] > value)
                    begin
                        store[i] = store[i-1];
                        i--;
                    end
                    store[i] = value;
                    held++;
                end
            KIND_REMOVE:
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.value = store[0];
                    for (i = 0; i + 1 < held; i++)
                        store[i] = store[i+1];
                    held--;
                end
            KIND_PEEK:
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = store[0];
            default: ;
        endcase
        r.occupancy = OCC_W'(held);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t checker: %s", $time, msg);
    endtask

    // Predict on each accepted request, then compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            awaited_q.delete();
            held = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_q.push_back(apply_request(kind_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.status    = status_t'(m_tuser);
                got.value     = m_tdata[31:0];
                got.occupancy = m_tdata[39:32];
                if (awaited_q.size() == 0)
                    note_failure($sformatf("result %0d arrived with no request waiting",
                                           result_index));
                else
                begin
                    want = awaited_q.pop_front();
                    if (got != want)
                        note_failure($sformatf({"result %0d: status exp %0d got %0d, ",
                                                "value exp %0d got %0d, ",
                                                "occupancy exp %0d got %0d"},
                                               result_index, want.status, got.status,
                                               want.value, got.value,
                                               want.occupancy, got.occupancy));
                end
                result_index++;
            end
        end
        pending = awaited_q.size();
    end

endmodule

### tb/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;    // [1:0] kind
    logic [31:0] s_tdata;    // [31:0] value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;    // [1:0] status
    logic [39:0] m_tdata;    // [31:0] result_value, [39:32] occupancy

    int fail_count;
    int pending;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_span  = 0;
    int cycle_count = 0;

    always #2 clk = ~clk;

    sorted_priority_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    sorted_priority_queue_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: switch between always ready, random and mostly stalled spans
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(4, 40);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Extremes, a narrow band near zero, else random; equal values recur
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3, 4: return 32'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Send one item, opening a new burst after a random gap when one runs out
    task automatic send_request(input kind_t kind, input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        int sel;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = KIND_INSERT;
        s_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty cases, extremes, equal values, unused kind
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_PEEK,   32'hFFFF_FFFF);
        send_request(KIND_NOP,    32'h1234_5678);
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_INSERT, 32'h7FFF_FFFF);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0001);
        send_request(KIND_PEEK,   32'h0000_0000);
        send_request(KIND_INSERT, 32'h0000_0005);
        send_request(KIND_INSERT, 32'h0000_0005);
        send_request(KIND_NOP,    32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_PEEK,   32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hAAAA_AAAA);
        send_request(KIND_INSERT, 32'h5555_5555);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);

        // Fill past full with random values, with peeks and no-ops now and then
        n = 0;
        while (n < DEPTH + 8)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                send_request(KIND_PEEK, $urandom);
            else if (sel == 1)
                send_request(KIND_NOP, $urandom);
            else
            begin
                send_request(KIND_INSERT, pick_value());
                n++;
            end
        end

        // Drain past empty, peeking now and then
        n = 0;
        while (n < DEPTH + 8)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(KIND_PEEK, $urandom);
            else
            begin
                send_request(KIND_REMOVE, $urandom);
                n++;
            end
        end

        // Mixed traffic at low occupancy
        for (n = 0; n < 100; n++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                send_request(KIND_INSERT, pick_value());
            else if (sel < 7)
                send_request(KIND_REMOVE, $urandom);
            else if (sel < 9)
                send_request(KIND_PEEK, $urandom);
            else
                send_request(KIND_NOP, $urandom);
        end
        s_tvalid <= 1'b0;

        // Wait for every result, then report
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/sorted_priority_queue_checker.sv
tb/sorted_priority_queue_tb.sv
